>>> src/sdi_pkg.sv
package sdi_pkg;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_DUMMY   = 4'd1,
    PH_CMD0    = 4'd2,
    PH_CMD8    = 4'd3,
    PH_CMD55   = 4'd4,
    PH_CMD41   = 4'd5,
    PH_CMD58   = 4'd6,
    PH_SUCCESS = 4'd7,
    PH_ERROR   = 4'd8
  } phase_t;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_BYTE  = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;
  localparam logic [1:0] ST_FAIL = 2'd3;

  localparam logic       CFG_TRANSFER_TIMEOUT = 1'b0;
  localparam logic       CFG_INIT_TIMEOUT     = 1'b1;
  localparam logic [15:0] TIMEOUT_RESET       = 16'd1000;

  localparam logic [7:0]  CMD_START   = 8'h40;
  localparam logic [7:0]  CRC_STOP    = 8'h01;
  localparam logic [7:0]  CRC_CMD0    = 8'h95;
  localparam logic [7:0]  CRC_CMD8    = 8'h87;
  localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
  localparam logic [31:0] ARG_ACMD41  = 32'h4000_0000;
  localparam logic [7:0]  FILL_BYTE   = 8'hFF;
  localparam logic [5:0]  R1_FIRST_IX = 6'd6;
  localparam logic [15:0] CNT_MAX     = 16'hFFFF;

  typedef struct packed {
    phase_t      phase;
    logic [5:0]  byte_index;
    logic        r1_found;
    logic [7:0]  r1_value;
    logic [2:0]  payload_count;
    logic [31:0] payload_shift;
    logic [31:0] captured;
    logic [15:0] transfer_elapsed;
    logic [15:0] init_elapsed;
  } seq_state_t;

  typedef struct packed {
    logic [31:0] captured_word;
    logic        abort_transfer;
    logic [1:0]  status;
    logic [7:0]  tx_byte;
    logic        send_request;
  } result_t;

  function automatic logic in_transfer(phase_t ph);
    return (ph >= PH_DUMMY) && (ph <= PH_CMD58);
  endfunction

  function automatic seq_state_t begin_xfer(seq_state_t s, phase_t ph);
    seq_state_t n;
    n = s;
    n.phase            = ph;
    n.byte_index       = '0;
    n.r1_found         = 1'b0;
    n.r1_value         = '0;
    n.payload_count    = '0;
    n.payload_shift    = '0;
    n.transfer_elapsed = '0;
    return n;
  endfunction

  function automatic logic [7:0] tx_for(phase_t ph, logic [5:0] idx);
    logic [7:0]  cmd;
    logic [31:0] arg;
    logic [7:0]  crc;
    logic [7:0]  b;
    arg = '0;
    crc = FILL_BYTE;
    cmd = '0;
    unique case (ph)
      PH_CMD0:  begin
        cmd = 8'd0;
        crc = CRC_CMD0;
      end
      PH_CMD8:  begin
        cmd = 8'd8;
        arg = ARG_CMD8;
        crc = CRC_CMD8;
      end
      PH_CMD55: cmd = 8'd55;
      PH_CMD41: begin
        cmd = 8'd41;
        arg = ARG_ACMD41;
      end
      PH_CMD58: cmd = 8'd58;
      default:  cmd = '0;
    endcase
    case (idx)
      6'd0:    b = cmd | CMD_START;
      6'd1:    b = arg[31:24];
      6'd2:    b = arg[23:16];
      6'd3:    b = arg[15:8];
      6'd4:    b = arg[7:0];
      6'd5:    b = crc | CRC_STOP;
      default: b = FILL_BYTE;
    endcase
    if (!(ph == PH_CMD0 || ph == PH_CMD8 || ph == PH_CMD55 ||
          ph == PH_CMD41 || ph == PH_CMD58)) begin
      b = FILL_BYTE;
    end
    return b;
  endfunction

endpackage

>>> src/sdi_step.sv
module sdi_step
  import sdi_pkg::*;
#(
  parameter int TRANSFER_BYTES = 20
) (
  input  seq_state_t  cur,
  input  logic [1:0]  action,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] transfer_timeout,
  input  logic [15:0] init_timeout,
  output seq_state_t  nxt,
  output result_t     res
);

  localparam logic [5:0] LAST_IX = 6'(TRANSFER_BYTES);

  seq_state_t s;
  seq_state_t f;
  logic       abort;
  logic [5:0] idx_inc;
  logic       ok;

  always_comb begin
    s       = cur;
    abort   = 1'b0;
    idx_inc = cur.byte_index + 6'd1;
    case (action)
      ACT_START: s = begin_xfer(cur, PH_DUMMY);
      ACT_TICK: begin
        if (in_transfer(cur.phase)) begin
          if (cur.transfer_elapsed != CNT_MAX) s.transfer_elapsed = cur.transfer_elapsed + 16'd1;
          if (cur.init_elapsed != CNT_MAX) s.init_elapsed = cur.init_elapsed + 16'd1;
          if (s.transfer_elapsed > transfer_timeout) begin
            s.phase = PH_ERROR;
            abort   = 1'b1;
          end
        end
      end
      ACT_BYTE: begin
        if (in_transfer(cur.phase)) begin
          if (!cur.r1_found) begin
            if (cur.byte_index >= R1_FIRST_IX && !rx_byte[7]) begin
              s.r1_found = 1'b1;
              s.r1_value = rx_byte;
            end
          end else if (cur.payload_count < 3'd4) begin
            s.payload_shift = {cur.payload_shift[23:0], rx_byte};
            s.payload_count = cur.payload_count + 3'd1;
          end
          s.byte_index = idx_inc;
        end
      end
      default: s = cur;
    endcase
  end

  // close the transfer and pick the next command
  always_comb begin
    f  = s;
    ok = s.r1_found;
    if (action == ACT_BYTE && in_transfer(cur.phase) &&
        (idx_inc >= LAST_IX || idx_inc == 6'd0)) begin
      unique case (s.phase)
        PH_DUMMY: f = begin_xfer(s, PH_CMD0);
        PH_CMD0: begin
          if (ok && s.r1_value == 8'h01) f = begin_xfer(s, PH_CMD8);
          else f.phase = PH_ERROR;
        end
        PH_CMD8: begin
          if (ok && s.r1_value == 8'h01) begin
            f = begin_xfer(s, PH_CMD55);
            if (s.payload_count == 3'd4) f.captured = s.payload_shift;
            f.init_elapsed = '0;
          end else begin
            f.phase = PH_ERROR;
          end
        end
        PH_CMD55: begin
          if (ok) f = begin_xfer(s, PH_CMD41);
          else f.phase = PH_ERROR;
        end
        PH_CMD41: begin
          if (ok && s.r1_value == 8'h00) f = begin_xfer(s, PH_CMD58);
          else if (ok && s.r1_value == 8'h01 && s.init_elapsed <= init_timeout)
            f = begin_xfer(s, PH_CMD55);
          else f.phase = PH_ERROR;
        end
        PH_CMD58: begin
          if (ok && s.r1_value == 8'h00) begin
            if (s.payload_count == 3'd4) f.captured = s.payload_shift;
            f.phase = PH_SUCCESS;
          end else begin
            f.phase = PH_ERROR;
          end
        end
        default: f.phase = PH_ERROR;
      endcase
    end
  end

  always_comb begin
    nxt                = f;
    res.captured_word  = f.captured;
    res.abort_transfer = abort;
    if (f.phase == PH_IDLE) res.status = ST_IDLE;
    else if (f.phase == PH_SUCCESS) res.status = ST_DONE;
    else if (f.phase == PH_ERROR) res.status = ST_FAIL;
    else res.status = ST_BUSY;
    if (in_transfer(f.phase)) begin
      res.send_request = 1'b1;
      res.tx_byte      = tx_for(f.phase, f.byte_index);
    end else begin
      res.send_request = 1'b0;
      res.tx_byte      = '0;
    end
  end

endmodule

>>> src/sd_spi_init_sequencer.sv
// SD card SPI-mode start-up sequencer.
// Input stream: one request per event. in_tuser carries the action
// (start/restart, millisecond tick, byte exchanged), in_tdata the byte
// received from the card. Every accepted request yields exactly one result
// on the output stream: whether to exchange another byte and which one, the
// sequence status, a transfer abort flag and the last captured R3/R7 word.
// The result is registered: a request accepted at an edge shows its result
// at out_tvalid right after that edge. Throughput is one request per cycle
// unless the receiver stalls; each update is a single pass through the step
// logic, which reads the sequencer state register and writes it back.
// The result register frees in the same cycle it is taken, so in_tready
// stays high while out_tready is high. When the receiver stalls, the result
// holds and in_tready drops until it is taken.
// Reset (rst_n low, synchronous) returns to idle, clears the captured word and
// loads both timeouts with 1000 ticks. The user must write a timeout register
// via the config port only while the block is idle; the block does not check it.
module sd_spi_init_sequencer
  import sdi_pkg::*;
#(
  parameter int TRANSFER_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] send_request, [8:1] tx_byte, [10:9] status, [11] abort_transfer,
  // [43:12] captured_word, [47:44] zero
  output logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  seq_state_t  state_r, state_nxt;
  result_t     res;
  logic [43:0] out_data_r;
  logic        out_valid_r;
  logic [15:0] xfer_to_r;
  logic [15:0] init_to_r;
  logic        in_accept;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;

  sdi_step #(.TRANSFER_BYTES(TRANSFER_BYTES)) u_step (
    .cur              (state_r),
    .action           (in_tuser),
    .rx_byte          (in_tdata),
    .transfer_timeout (xfer_to_r),
    .init_timeout     (init_to_r),
    .nxt              (state_nxt),
    .res              (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= begin_xfer('0, PH_IDLE);
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        state_r <= state_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xfer_to_r <= TIMEOUT_RESET;
      init_to_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      if (cfg_addr == CFG_TRANSFER_TIMEOUT) xfer_to_r <= cfg_wdata;
      if (cfg_addr == CFG_INIT_TIMEOUT) init_to_r <= cfg_wdata;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_data_r};

  a_abort_is_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[11] |-> out_data_r[10:9] == ST_FAIL)
    else $error("abort without error status");

  a_busy_requests: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[0] == (out_data_r[10:9] == ST_BUSY)))
    else $error("send request does not match busy status");

  a_idle_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[0] |-> out_data_r[8:1] == 8'd0)
    else $error("tx byte set without send request");

  a_capture_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !in_accept |=> $stable(state_r.captured))
    else $error("captured word changed without a request");

endmodule

>>> dv/sdi_seq_monitor.sv
module sdi_seq_monitor
  import sdi_pkg::*;
#(
  parameter int XFER_BYTES = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          mismatches,
  output int          pending,
  output int          checked
);

  localparam logic [7:0] OP_GO_IDLE   = 8'd0;
  localparam logic [7:0] OP_SEND_IF   = 8'd8;
  localparam logic [7:0] OP_APP_CMD   = 8'd55;
  localparam logic [7:0] OP_SEND_OP   = 8'd41;
  localparam logic [7:0] OP_READ_OCR  = 8'd58;
  localparam logic [7:0] R1_IN_IDLE   = 8'h01;
  localparam logic [7:0] R1_READY     = 8'h00;
  localparam int         REPORT_LINES = 30;

  phase_t      ph;
  logic [5:0]  bidx;
  logic        r1_seen;
  logic [7:0]  r1;
  logic [2:0]  pay_n;
  logic [31:0] pay_sr;
  logic [31:0] cap_word;
  logic [15:0] xfer_ms;
  logic [15:0] init_ms;
  logic [15:0] xfer_limit;
  logic [15:0] init_limit;
  result_t     due_q[$];
  int          err_n;
  int          got_n;

  function automatic logic live(phase_t p);
    return (p >= PH_DUMMY) && (p <= PH_CMD58);
  endfunction

  function automatic logic [7:0] cmd_byte(phase_t p, logic [5:0] idx);
    logic [7:0]  op;
    logic [31:0] arg;
    logic [7:0]  crc;
    op = '0;
    arg = '0;
    crc = FILL_BYTE;
    case (p)
      PH_CMD0: begin
        op = OP_GO_IDLE;
        crc = CRC_CMD0;
      end
      PH_CMD8: begin
        op = OP_SEND_IF;
        arg = ARG_CMD8;
        crc = CRC_CMD8;
      end
      PH_CMD55: op = OP_APP_CMD;
      PH_CMD41: begin
        op = OP_SEND_OP;
        arg = ARG_ACMD41;
      end
      PH_CMD58: op = OP_READ_OCR;
      default: return FILL_BYTE;
    endcase
    if (idx == 6'd0) return op | CMD_START;
    if (idx <= 6'd4) return 8'(arg >> (8 * (4 - int'(idx))));
    if (idx == 6'd5) return crc | CRC_STOP;
    return FILL_BYTE;
  endfunction

  task automatic open_xfer(input phase_t p);
    ph = p;
    bidx = '0;
    r1_seen = 1'b0;
    r1 = '0;
    pay_n = '0;
    pay_sr = '0;
    xfer_ms = '0;
  endtask

  task automatic close_xfer();
    case (ph)
      PH_DUMMY: open_xfer(PH_CMD0);
      PH_CMD0: begin
        if (r1_seen && r1 == R1_IN_IDLE) begin
          open_xfer(PH_CMD8);
        end else begin
          ph = PH_ERROR;
        end
      end
      PH_CMD8: begin
        if (r1_seen && r1 == R1_IN_IDLE) begin
          if (pay_n == 3'd4) cap_word = pay_sr;
          init_ms = '0;
          open_xfer(PH_CMD55);
        end else begin
          ph = PH_ERROR;
        end
      end
      PH_CMD55: begin
        if (r1_seen) begin
          open_xfer(PH_CMD41);
        end else begin
          ph = PH_ERROR;
        end
      end
      PH_CMD41: begin
        if (r1_seen && r1 == R1_READY) begin
          open_xfer(PH_CMD58);
        end else if (r1_seen && r1 == R1_IN_IDLE && init_ms <= init_limit) begin
          open_xfer(PH_CMD55);
        end else begin
          ph = PH_ERROR;
        end
      end
      PH_CMD58: begin
        if (r1_seen && r1 == R1_READY) begin
          if (pay_n == 3'd4) cap_word = pay_sr;
          ph = PH_SUCCESS;
        end else begin
          ph = PH_ERROR;
        end
      end
      default: ph = PH_ERROR;
    endcase
  endtask

  task automatic step_sequencer(input logic [1:0] act, input logic [7:0] rx,
                                output result_t r);
    logic abort_hit;
    abort_hit = 1'b0;
    case (act)
      ACT_START: open_xfer(PH_DUMMY);
      ACT_TICK: begin
        if (live(ph)) begin
          if (xfer_ms != CNT_MAX) xfer_ms = xfer_ms + 16'd1;
          if (init_ms != CNT_MAX) init_ms = init_ms + 16'd1;
          if (xfer_ms > xfer_limit) begin
            ph = PH_ERROR;
            abort_hit = 1'b1;
          end
        end
      end
      ACT_BYTE: begin
        if (live(ph)) begin
          if (!r1_seen) begin
            if (bidx >= R1_FIRST_IX && !rx[7]) begin
              r1_seen = 1'b1;
              r1 = rx;
            end
          end else if (pay_n < 3'd4) begin
            pay_sr = {pay_sr[23:0], rx};
            pay_n = pay_n + 3'd1;
          end
          bidx = bidx + 6'd1;
          if (int'(bidx) >= XFER_BYTES || bidx == 6'd0) close_xfer();
        end
      end
      default: ;
    endcase
    case (ph)
      PH_IDLE:    r.status = ST_IDLE;
      PH_SUCCESS: r.status = ST_DONE;
      PH_ERROR:   r.status = ST_FAIL;
      default:    r.status = ST_BUSY;
    endcase
    r.send_request = live(ph);
    r.tx_byte = live(ph) ? cmd_byte(ph, bidx) : 8'd0;
    r.abort_transfer = abort_hit;
    r.captured_word = cap_word;
  endtask

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    err_n++;
    if (err_n <= REPORT_LINES) begin
      $display("result %0d: %s got 0x%0h want 0x%0h", got_n, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      xfer_limit = TIMEOUT_RESET;
      init_limit = TIMEOUT_RESET;
      open_xfer(PH_IDLE);
      cap_word = '0;
      init_ms = '0;
      due_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_TRANSFER_TIMEOUT) xfer_limit = cfg_wdata;
        else init_limit = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          report("result with no request waiting", out_tdata[31:0], '0);
        end else begin
          want = due_q.pop_front();
          got = result_t'(out_tdata[43:0]);
          if (got.send_request !== want.send_request)
            report("send_request", 32'(got.send_request), 32'(want.send_request));
          if (got.tx_byte !== want.tx_byte)
            report("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
          if (got.status !== want.status)
            report("status", 32'(got.status), 32'(want.status));
          if (got.abort_transfer !== want.abort_transfer)
            report("abort_transfer", 32'(got.abort_transfer), 32'(want.abort_transfer));
          if (got.captured_word !== want.captured_word)
            report("captured_word", got.captured_word, want.captured_word);
          if (out_tdata[47:44] !== 4'd0)
            report("pad bits", 32'(out_tdata[47:44]), '0);
        end
        got_n++;
      end
      if (in_tvalid && in_tready) begin
        step_sequencer(in_tuser, in_tdata, want);
        due_q.push_back(want);
      end
    end
    mismatches <= err_n;
    pending <= due_q.size();
    checked <= got_n;
  end

endmodule

>>> dv/tb.sv
module tb;
  import sdi_pkg::*;

  localparam int         XFER_BYTES   = 20;
  localparam int         CYCLE_LIMIT  = 6_000_000;
  localparam int         RANDOM_ITEMS = 1650;
  localparam int         CALM_ITEMS   = 250;
  localparam int         SAT_TICKS    = 65600;
  localparam logic [1:0] ACT_NONE     = 2'd3;
  localparam logic [7:0] R1_IN_IDLE   = 8'h01;
  localparam logic [7:0] R1_READY     = 8'h00;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  in_tuser = '0;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] send_request, [8:1] tx_byte, [10:9] status, [11] abort_transfer,
  // [43:12] captured_word, [47:44] zero
  logic [47:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [15:0] cfg_wdata = '0;

  int   mismatches;
  int   pending;
  int   checked;
  logic in_acc = 1'b0;
  bit   tx_idle_on = 1'b1;
  bit   rx_idle_on = 1'b1;
  int   rx_stall_left = 0;
  int   cycles = 0;
  int   sent = 0;
  int   runs = 0;
  int   limit_writes = 0;
  int   calm_at = 0;

  sd_spi_init_sequencer #(.TRANSFER_BYTES(XFER_BYTES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  sdi_seq_monitor #(.XFER_BYTES(XFER_BYTES)) i_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    in_acc <= in_tvalid && in_tready;
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stalls in random bursts
  always @(negedge clk) begin
    if (!rx_idle_on || !rst_n) begin
      out_tready <= 1'b1;
    end else if (rx_stall_left > 0) begin
      out_tready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      rx_stall_left <= $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic push_req(input logic [1:0] act, input logic [7:0] rx);
    if (calm_at > 0 && sent >= calm_at) begin
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
    end
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= rx;
    do @(negedge clk); while (!in_acc);
    sent++;
  endtask

  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic write_reg(input logic addr, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    limit_writes++;
  endtask

  function automatic logic [15:0] pick_limit();
    case ($urandom_range(0, 8))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'd5;
      4: return 16'd30;
      5: return TIMEOUT_RESET;
      6: return CNT_MAX;
      default: return 16'($urandom_range(1, 400));
    endcase
  endfunction

  function automatic logic [7:0] r1_pick(input logic [7:0] good);
    if ($urandom_range(0, 15) != 0) return good;
    return 8'($urandom_range(0, 127));
  endfunction

  // one card transfer: R1 at a random slot from index 6 (sometimes none), ticks and noise mixed in
  task automatic card_transfer(input logic [7:0] r1v, input int tick_odds);
    int pos;
    logic [7:0] b;
    if ($urandom_range(0, 39) == 0) pos = XFER_BYTES;
    else if ($urandom_range(0, 3) != 0) pos = $urandom_range(6, XFER_BYTES - 5);
    else pos = $urandom_range(XFER_BYTES - 4, XFER_BYTES - 1);
    for (int i = 0; i < XFER_BYTES; i++) begin
      if (tick_odds > 0 && $urandom_range(1, tick_odds) == 1)
        push_req(ACT_TICK, 8'($urandom));
      if ($urandom_range(0, 149) == 0)
        push_req(2'($urandom_range(0, 3)), 8'($urandom));
      if (i == pos) b = r1v;
      else if (i < pos && i >= int'(R1_FIRST_IX)) b = 8'($urandom) | 8'h80;
      else b = 8'($urandom);
      push_req(ACT_BYTE, b);
    end
  endtask

  task automatic startup_run(input int tick_odds);
    push_req(ACT_START, 8'($urandom));
    card_transfer(8'($urandom), tick_odds);
    card_transfer(r1_pick(R1_IN_IDLE), tick_odds);
    card_transfer(r1_pick(R1_IN_IDLE), tick_odds);
    repeat ($urandom_range(0, 4)) begin
      card_transfer(8'($urandom_range(0, 127)), tick_odds);
      card_transfer(r1_pick(R1_IN_IDLE), tick_odds);
    end
    card_transfer(8'($urandom_range(0, 127)), tick_odds);
    card_transfer(r1_pick(R1_READY), tick_odds);
    card_transfer(r1_pick(R1_READY), tick_odds);
    runs++;
  endtask

  initial begin
    int target;
    int odds;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // idle: byte, tick and an unknown action are ignored
    push_req(ACT_BYTE, 8'h00);
    push_req(ACT_TICK, 8'hFF);
    push_req(ACT_NONE, 8'hA5);
    // restart while busy
    push_req(ACT_START, 8'h5A);
    push_req(ACT_BYTE, 8'h7F);
    push_req(ACT_TICK, 8'h80);
    push_req(ACT_START, 8'h01);
    push_req(ACT_NONE, 8'hFE);
    // zero limit: the first tick aborts, later requests are ignored
    wait_results();
    write_reg(CFG_TRANSFER_TIMEOUT, 16'd0);
    write_reg(CFG_INIT_TIMEOUT, 16'd0);
    push_req(ACT_START, 8'h00);
    push_req(ACT_TICK, 8'h00);
    push_req(ACT_BYTE, 8'h00);
    push_req(ACT_TICK, 8'hFF);
    // limit 1: the second tick aborts
    wait_results();
    write_reg(CFG_TRANSFER_TIMEOUT, 16'd1);
    push_req(ACT_START, 8'hFF);
    push_req(ACT_TICK, 8'h55);
    push_req(ACT_BYTE, 8'h00);
    push_req(ACT_TICK, 8'hAA);

    // saturate both counters inside the retry loop; limit 65535 never fires
    wait_results();
    write_reg(CFG_TRANSFER_TIMEOUT, CNT_MAX);
    write_reg(CFG_INIT_TIMEOUT, CNT_MAX);
    tx_idle_on = 1'b0;
    push_req(ACT_START, 8'h00);
    card_transfer(8'h3C, 0);
    card_transfer(R1_IN_IDLE, 0);
    card_transfer(R1_IN_IDLE, 0);
    repeat (SAT_TICKS) push_req(ACT_TICK, 8'($urandom));
    card_transfer(R1_READY, 0);
    card_transfer(R1_IN_IDLE, 0);
    card_transfer(R1_IN_IDLE, 0);
    card_transfer(R1_READY, 0);
    card_transfer(R1_READY, 0);
    tx_idle_on = 1'b1;

    target = sent + RANDOM_ITEMS;
    calm_at = target - CALM_ITEMS;
    while (sent < target) begin
      if (sent < calm_at && $urandom_range(0, 2) == 0) begin
        wait_results();
        write_reg(CFG_TRANSFER_TIMEOUT, pick_limit());
        write_reg(CFG_INIT_TIMEOUT, pick_limit());
      end
      case ($urandom_range(0, 4))
        0: odds = 0;
        1: odds = 3;
        2: odds = 6;
        3: odds = 12;
        default: odds = 40;
      endcase
      startup_run(odds);
      repeat ($urandom_range(0, 2)) push_req(2'($urandom_range(0, 3)), 8'($urandom));
      if (sent < calm_at && $urandom_range(0, 3) == 0) wait_results();
    end

    wait_results();
    repeat (4) @(negedge clk);
    $display("%0d requests, %0d start-up runs, %0d-tick saturation run, %0d results checked",
             sent, runs, SAT_TICKS, checked);
    $display("%0d limit writes incl. 0, 1 and 65535; restarts, aborts and stray actions mixed in",
             limit_writes);
    if (mismatches + pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
